FILE: hdl/prr_pkg.sv
// Shared constants and types for the PRBS31 ranged random unit.
// No dependencies; every design file imports this package.
package prr_pkg;

   localparam int LFSR_BITS  = 31;
   localparam int VALUE_BITS = 16;
   localparam int TAP_HI     = 30;
   localparam int TAP_LO     = 27;
   localparam int CNT_BITS   = $clog2(LFSR_BITS);

   localparam logic [LFSR_BITS-1:0] LFSR_RESET = 31'h2A55_1199;

   // Status returned by the modulo unit to the sequencer.
   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] remainder;
   } prr_mod_status_type;

   function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] s);
      logic fb;
      fb = ~(s[TAP_HI] ^ s[TAP_LO]);
      return {s[LFSR_BITS-2:0], fb};
   endfunction

endpackage

FILE: hdl/prr_chan_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on prr_pkg for field widths.
interface prr_req_if import prr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] lower_bound;
   logic [VALUE_BITS-1:0] upper_bound;

   modport source (output valid, output lower_bound, output upper_bound, input ready);
   modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface prr_rsp_if import prr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  range_error;

   modport source (output valid, output value, output range_error, input ready);
   modport sink   (input valid, input value, input range_error, output ready);
endinterface

FILE: hdl/prbs31_ranged_random_unit.sv
// PRBS31 ranged random unit: advance the LFSR, return (lfsr mod span) + lower.
// A valid range runs through the 31-step restoring modulo unit (state RUN), then
// state FIN writes the output register; a range error goes straight to FIN. No new
// request is taken while one is in work or while a finished result waits for the
// output register.
// Reset (synchronous, active high) loads LFSR 0x2A551199 and empties the output.
module prbs31_ranged_random_unit import prr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   prr_req_if.sink      req_if,
   prr_rsp_if.source    rsp_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [LFSR_BITS-1:0]  lfsr_ff, lfsr_in;
   logic [VALUE_BITS-1:0] lower_ff, lower_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  req_xfer;
   logic                  mod_start;
   logic [VALUE_BITS-1:0] req_span;
   logic                  range_bad;
   prr_mod_status_type    mod_status;

   assign req_xfer  = req_if.valid && req_if.ready;
   assign req_span  = req_if.upper_bound - req_if.lower_bound;
   assign range_bad = req_if.upper_bound <= req_if.lower_bound;
   assign mod_start = req_xfer && !range_bad;

   prr_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (lfsr_in),
      .span     (req_span),
      .status   (mod_status)
   );

   always_comb begin
      state_in     = state_ff;
      lfsr_in      = lfsr_ff;
      lower_in     = lower_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               lfsr_in  = lfsr_step(lfsr_ff);
               lower_in = req_if.lower_bound;
               err_in   = range_bad;
               state_in = range_bad ? ST_FIN : ST_RUN;
            end
         end
         ST_RUN: begin
            if (mod_status.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_value_in = err_ff ? lower_ff : mod_status.remainder + lower_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lfsr_ff      <= LFSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lower_ff     <= lower_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.value       = rsp_value_ff;
   assign rsp_if.range_error = rsp_err_ff;

endmodule

FILE: hdl/prr_mod_unit.sv
// Restoring modulo unit: 31-bit dividend by 16-bit span, one bit per cycle.
// Depends on prr_pkg.
module prr_mod_unit import prr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [LFSR_BITS-1:0]  dividend,
   input  logic [VALUE_BITS-1:0] span,
   output prr_mod_status_type    status
);

   logic [LFSR_BITS-1:0]  dividend_ff, dividend_in;
   logic [VALUE_BITS-1:0] span_ff, span_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;

   always_comb begin
      trial = {rem_ff, dividend_ff[LFSR_BITS-1]};
      diff  = trial - {1'b0, span_ff};
   end

   always_comb begin
      dividend_in = dividend_ff;
      span_in     = span_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      if (start) begin
         dividend_in = dividend;
         span_in     = span;
         rem_in      = '0;
         count_in    = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[LFSR_BITS-2:0], 1'b0};
         // keep the difference only when the subtraction does not borrow
         if (!diff[VALUE_BITS]) begin
            rem_in = diff[VALUE_BITS-1:0];
         end else begin
            rem_in = trial[VALUE_BITS-1:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_BITS'(LFSR_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

FILE: test/tb.sv
// Testbench for prbs31_ranged_random_unit: directed table of ranges, then random ranges.
// Every response is checked against its typed table result or a local PRBS31 modulo predictor.
// Depends on prr_pkg, prr_chan_if and the unit's RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_DRAWS = 1300;
   localparam int          QUIET_FROM   = 1150;  // no idling on either side from here on
   localparam int          HOLD_AT      = 200;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 40;
   localparam longint      LIMIT_NS     = 2_000_000;
   localparam logic [30:0] PRBS_SEED    = 31'h2A55_1199;

   typedef struct packed {
      logic [15:0] value;
      logic        range_error;
   } draw_result_type;

   typedef struct packed {
      logic [15:0] lower;
      logic [15:0] upper;
      logic        known;        // expected result typed in below
      logic [15:0] value;
      logic        range_error;
   } draw_row_type;

   localparam int N_ROWS = 20;
   localparam draw_row_type DIRECTED_DRAWS [N_ROWS] = '{
      '{16'h0000, 16'hFFFF, 1'b1, 16'd30684, 1'b0},  // first draw after reset, full range
      '{16'h0000, 16'h0000, 1'b1, 16'h0000,  1'b1},  // empty range at zero
      '{16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF,  1'b1},  // empty range at the top
      '{16'hFFFF, 16'h0000, 1'b1, 16'hFFFF,  1'b1},  // fully inverted
      '{16'h1234, 16'h1233, 1'b1, 16'h1234,  1'b1},  // inverted by one
      '{16'h0000, 16'h0001, 1'b1, 16'h0000,  1'b0},  // span of one
      '{16'hFFFE, 16'hFFFF, 1'b1, 16'hFFFE,  1'b0},
      '{16'h7FFF, 16'h8000, 1'b1, 16'h7FFF,  1'b0},
      '{16'h0000, 16'h0002, 1'b0, 16'h0000,  1'b0},
      '{16'h0000, 16'h8000, 1'b0, 16'h0000,  1'b0},
      '{16'h8000, 16'hFFFF, 1'b0, 16'h0000,  1'b0},
      '{16'h5555, 16'hAAAA, 1'b0, 16'h0000,  1'b0},
      '{16'hAAAA, 16'h5555, 1'b1, 16'hAAAA,  1'b1},
      '{16'h0001, 16'hFFFF, 1'b0, 16'h0000,  1'b0},
      '{16'hFFFE, 16'h0000, 1'b1, 16'hFFFE,  1'b1},
      '{16'h0000, 16'h0003, 1'b0, 16'h0000,  1'b0},
      '{16'h0100, 16'h0107, 1'b0, 16'h0000,  1'b0},
      '{16'h00FF, 16'hFF00, 1'b0, 16'h0000,  1'b0},
      '{16'hFFFF, 16'hFFFE, 1'b1, 16'hFFFF,  1'b1},
      '{16'h0000, 16'hFFFF, 1'b0, 16'h0000,  1'b0}
   };

   logic clock;
   logic reset;

   prr_req_if req_ch ();
   prr_rsp_if rsp_ch ();

   prbs31_ranged_random_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic [30:0]     draw_state = PRBS_SEED;
   draw_result_type pending_draws [$];
   int              fail_count    = 0;
   int              checked_count = 0;
   int              request_count = 0;
   int              range_errors  = 0;
   int              unit_spans    = 0;
   bit              send_idle_on  = 1'b1;
   bit              rsp_idle_on   = 1'b1;
   bit              hold_request  = 1'b0;

   function automatic logic [30:0] next_prbs(input logic [30:0] s);
      return {s[29:0], ~(s[30] ^ s[27])};
   endfunction

   function automatic draw_result_type ranged_draw(input logic [30:0] s,
                                                   input logic [15:0] lo,
                                                   input logic [15:0] hi);
      draw_result_type r;
      logic [30:0]     span;
      if (hi > lo) begin
         span = {15'd0, hi - lo};
         r.value = 16'(s % span) + lo;
         r.range_error = 1'b0;
      end else begin
         r.value = lo;
         r.range_error = 1'b1;
      end
      return r;
   endfunction

   // Offer one request, hold it until the transfer, then record what it must return.
   task automatic offer_draw(input logic [15:0] lo, input logic [15:0] hi,
                             input logic known, input draw_result_type typed_result);
      int gap;
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.lower_bound <= lo;
      req_ch.upper_bound <= hi;
      do @(posedge clock); while (!req_ch.ready);
      draw_state = next_prbs(draw_state);
      pending_draws.push_back(known ? typed_result : ranged_draw(draw_state, lo, hi));
      request_count++;
      if (hi <= lo) range_errors++;
      else if (hi - lo == 16'd1) unit_spans++;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off while requests keep coming.
   initial begin
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : response_check
      draw_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_draws.size() == 0) begin
            $error("unexpected response: value %h range_error %b",
                   rsp_ch.value, rsp_ch.range_error);
            fail_count++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_ch.value !== want.value) begin
               $error("value: expected %h, actual %h", want.value, rsp_ch.value);
               fail_count++;
            end
            if (rsp_ch.range_error !== want.range_error) begin
               $error("range_error: expected %b, actual %b",
                      want.range_error, rsp_ch.range_error);
               fail_count++;
            end
            checked_count++;
         end
      end
   end

   initial begin
      logic [15:0]  lo, hi, a, b;
      draw_row_type row;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.lower_bound <= 16'h0000;
      req_ch.upper_bound <= 16'h0000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_ROWS; i++) begin
         row = DIRECTED_DRAWS[i];
         offer_draw(row.lower, row.upper, row.known, '{row.value, row.range_error});
      end

      for (int i = 0; i < RANDOM_DRAWS; i++) begin
         send_idle_on = (i < QUIET_FROM) && ((i / 64) % 4 != 3);
         rsp_idle_on  = send_idle_on;
         if (i == HOLD_AT) hold_request = 1'b1;
         case ($urandom_range(0, 9))
            0: begin
               lo = 16'($urandom);
               hi = 16'($urandom_range(0, lo));
            end
            1: begin
               lo = 16'($urandom_range(0, 16'hFFFE));
               hi = lo + 16'd1;
            end
            2, 3: begin
               lo = 16'($urandom_range(0, 16'hFFF0));
               hi = lo + 16'($urandom_range(2, 15));
            end
            9: begin
               lo = 16'($urandom);
               hi = 16'($urandom);
            end
            default: begin
               a = 16'($urandom);
               b = 16'($urandom);
               lo = (a < b) ? a : b;
               hi = (a < b) ? b : a;
            end
         endcase
         offer_draw(lo, hi, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses to %0d requests, %0d of them empty or inverted ranges",
               checked_count, request_count, range_errors);
      $display("and %0d spans of one, with random stalls and a %0d-cycle response hold-off.",
               unit_spans, HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
